// File: hdl/price_level_order_book_defines.svh
// Assertion macros for the order book checker.
`ifndef PRICE_LEVEL_ORDER_BOOK_DEFINES_SVH
`define PRICE_LEVEL_ORDER_BOOK_DEFINES_SVH
// Check a property on every clock, off while reset is held.
`define PLOB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every clock, reset included.
`define PLOB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: hdl/plob_pkg.sv
package plob_pkg;
  localparam int unsigned TableSlotsDef  = 1024;
  localparam int unsigned PriceLevelsDef = 4096;
  localparam int unsigned PriceW = 31;
  localparam int unsigned QtyW   = 31;
  localparam int unsigned IdW    = 64;
  localparam int unsigned TotW   = 48;
  localparam int unsigned FuncW  = 3;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [FuncW-1:0] FUNC_ADD  = 3'd0;
  localparam logic [FuncW-1:0] FUNC_EXEC = 3'd1;
  localparam logic [FuncW-1:0] FUNC_CANC = 3'd2;
  localparam logic [FuncW-1:0] FUNC_DEL  = 3'd3;
  localparam logic [FuncW-1:0] FUNC_REPL = 3'd4;

  localparam logic [CfgIdxW-1:0] REG_LOWEST  = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_HIGHEST = 1'b1;

  localparam logic [1:0] FLAG_EMPTY = 2'd0;
  localparam logic [1:0] FLAG_LIVE  = 2'd1;
  localparam logic [1:0] FLAG_TOMB  = 2'd2;

  localparam logic SIDE_BUY = 1'b0;

  typedef struct packed {
    logic [FuncW-1:0]  func;
    logic [IdW-1:0]    order_id;
    logic [IdW-1:0]    new_order_id;
    logic              side;
    logic [PriceW-1:0] price;
    logic [QtyW-1:0]   quantity;
  } in_item_t;

  typedef struct packed {
    logic              ok;
    logic              order_side;
    logic [PriceW-1:0] order_price;
    logic [QtyW-1:0]   remaining;
    logic [TotW-1:0]   level_total;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;        // latch input item, start probe at home slot
    logic clr_step;    // clear slot flags sweep step
    logic probe_rd;    // issue slot read at probe pointer
    logic probe_adv;   // advance probe pointer and count
    logic lvl_rd;      // read level total of the current side/level
    logic lvl_wr;      // write back level total
    logic slot_wr;     // write slot at probe pointer
    logic find_new;    // switch item to inserting new id (replace)
    logic emit;        // present result
    logic emit_fail;   // present failure
  } plob_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clr_done;
    logic price_ok;
    logic is_add;
    logic is_find;     // execute, cancel, delete
    logic is_repl;
    logic hit;         // live slot with matching key
    logic empty;       // slot empty
    logic free;        // slot not live
    logic probe_last;  // all slots walked
  } plob_sts_t;
endpackage

// File: hdl/plob_datapath.sv
module plob_datapath #(
  parameter int unsigned TABLE_SLOTS  = plob_pkg::TableSlotsDef,
  parameter int unsigned PRICE_LEVELS = plob_pkg::PriceLevelsDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  plob_pkg::in_item_t           item,
  input  logic                         cfg_we,
  input  logic [plob_pkg::CfgIdxW-1:0] cfg_idx,
  input  logic [plob_pkg::PriceW-1:0]  cfg_data,
  input  plob_pkg::plob_cmd_t          cmd,
  output plob_pkg::plob_sts_t          sts,
  output logic                         res_vld,
  output plob_pkg::out_item_t          res
);
  localparam int unsigned SW = $clog2(TABLE_SLOTS);
  localparam int unsigned LW = $clog2(PRICE_LEVELS);
  localparam int unsigned CW = SW + 1;
  localparam int unsigned PW = plob_pkg::PriceW;
  localparam int unsigned QW = plob_pkg::QtyW;
  localparam int unsigned TW = plob_pkg::TotW;

  // Slot table: key, side/level, quantity in one memory; flags apart.
  typedef struct packed {
    logic [plob_pkg::IdW-1:0] key;
    logic                     side;
    logic [LW-1:0]            lvl;
    logic [QW-1:0]            qty;
  } slot_t;

  slot_t      slot_mem [TABLE_SLOTS];
  logic [1:0] flag_mem [TABLE_SLOTS];
  logic [TW-1:0] tot_mem [2*PRICE_LEVELS];

  logic [PW-1:0] lo_r, hi_r;
  plob_pkg::in_item_t it_r, it_nxt;
  logic [SW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] clr_r;
  logic          clr_done_r;
  slot_t         srd_r;
  logic [1:0]    frd_r;
  logic [TW-1:0] trd_r;
  logic          side_r;       // side of affected order
  logic [LW-1:0] lvl_r;        // level of affected order
  logic [QW-1:0] oldq_r;       // remaining quantity of affected order
  logic          sub_r;        // level op subtracts
  logic [QW-1:0] delta_r;
  logic          res_vld_r;
  plob_pkg::out_item_t res_r;

  // Configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r <= '0;
      hi_r <= PW'(4095);
    end else if (cfg_we) begin
      if (cfg_idx == plob_pkg::REG_LOWEST) lo_r <= cfg_data;
      else hi_r <= cfg_data;
    end
  end

  // Price check on the latched item.
  logic [PW:0]   top_w, lim_w;
  logic [PW-1:0] dpr_w;
  logic          pr_ok;
  assign top_w = {1'b0, lo_r} + (PW+1)'(PRICE_LEVELS - 1);
  assign lim_w = ({1'b0, hi_r} < top_w) ? {1'b0, hi_r} : top_w;
  assign pr_ok = (it_r.price >= lo_r) && ({1'b0, it_r.price} <= lim_w);
  assign dpr_w = it_r.price - lo_r;

  logic hit_w;
  assign hit_w = (frd_r == plob_pkg::FLAG_LIVE) && (srd_r.key == it_r.order_id);

  logic          tclr_on_r;

  assign sts.clr_done   = clr_done_r && !tclr_on_r;
  assign sts.price_ok   = pr_ok;
  assign sts.is_add     = (it_r.func == plob_pkg::FUNC_ADD);
  assign sts.is_find    = (it_r.func == plob_pkg::FUNC_EXEC) ||
                          (it_r.func == plob_pkg::FUNC_CANC) ||
                          (it_r.func == plob_pkg::FUNC_DEL);
  assign sts.is_repl    = (it_r.func == plob_pkg::FUNC_REPL);
  assign sts.hit        = hit_w;
  assign sts.empty      = (frd_r == plob_pkg::FLAG_EMPTY);
  assign sts.free       = (frd_r != plob_pkg::FLAG_LIVE);
  assign sts.probe_last = (cnt_r == CW'(TABLE_SLOTS - 1));

  // Item latch and probe pointer.
  always_comb begin
    it_nxt  = it_r;
    ptr_nxt = ptr_r;
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      it_nxt  = item;
      ptr_nxt = item.order_id[SW-1:0];
      cnt_nxt = '0;
    end else if (cmd.find_new) begin
      it_nxt.order_id = it_r.new_order_id;
      ptr_nxt = it_r.new_order_id[SW-1:0];
      cnt_nxt = '0;
    end else if (cmd.probe_adv) begin
      ptr_nxt = ptr_r + SW'(1);
      cnt_nxt = cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    it_r  <= it_nxt;
    ptr_r <= ptr_nxt;
    cnt_r <= cnt_nxt;
  end

  // Flag clearing sweep after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= '0;
      clr_done_r <= 1'b0;
    end else if (cmd.clr_step) begin
      clr_r <= clr_r + SW'(1);
      if (clr_r == SW'(TABLE_SLOTS - 1)) clr_done_r <= 1'b1;
    end
  end

  // Slot write data.
  slot_t  swd;
  logic [1:0] fwd;
  always_comb begin
    swd = srd_r;
    fwd = plob_pkg::FLAG_LIVE;
    if (sts.is_add || cmd.find_new || (sts.is_repl && sts.free)) begin
      swd.key  = it_r.order_id;
      swd.side = sts.is_add ? it_r.side : side_r;
      swd.lvl  = dpr_w[LW-1:0];
      swd.qty  = it_r.quantity;
    end else if (sts.is_find && it_r.func != plob_pkg::FUNC_DEL &&
                 srd_r.qty > it_r.quantity) begin
      swd.qty = srd_r.qty - it_r.quantity;
    end else begin
      fwd = plob_pkg::FLAG_TOMB;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) flag_mem[clr_r] <= plob_pkg::FLAG_EMPTY;
    else if (cmd.slot_wr) flag_mem[ptr_r] <= fwd;
    if (cmd.slot_wr) slot_mem[ptr_r] <= swd;
    if (cmd.probe_rd) begin
      srd_r <= slot_mem[ptr_r];
      frd_r <= flag_mem[ptr_r];
    end
  end

  // Level op setup, taken when slot is written.
  always_ff @(posedge clk) begin
    if (cmd.slot_wr) begin
      if (fwd == plob_pkg::FLAG_TOMB) begin
        side_r  <= srd_r.side;
        lvl_r   <= srd_r.lvl;
        sub_r   <= 1'b1;
        delta_r <= srd_r.qty;
        oldq_r  <= '0;
      end else if (swd.key == it_r.order_id && (sts.is_add || !hit_w)) begin
        side_r  <= swd.side;
        lvl_r   <= swd.lvl;
        sub_r   <= 1'b0;
        delta_r <= it_r.quantity;
        oldq_r  <= it_r.quantity;
      end else begin
        side_r  <= srd_r.side;
        lvl_r   <= srd_r.lvl;
        sub_r   <= 1'b1;
        delta_r <= it_r.quantity;
        oldq_r  <= swd.qty;
      end
    end
  end

  // Level totals: emptied after reset by their own clearing sweep.
  logic [TW:0]   sum_w;
  logic [TW-1:0] tnew_w;
  logic [LW:0]   taddr;
  assign taddr  = {side_r, lvl_r};
  assign sum_w  = {1'b0, trd_r} + (TW+1)'(delta_r);
  assign tnew_w = sub_r ? ((trd_r > TW'(delta_r)) ? trd_r - TW'(delta_r) : '0)
                        : (sum_w[TW] ? {TW{1'b1}} : sum_w[TW-1:0]);

  logic [LW:0] tclr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tclr_r    <= '0;
      tclr_on_r <= 1'b1;
    end else if (tclr_on_r) begin
      tclr_r <= tclr_r + (LW+1)'(1);
      if (tclr_r == (LW+1)'(2*PRICE_LEVELS - 1)) tclr_on_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tclr_on_r) tot_mem[tclr_r] <= '0;
    else if (cmd.lvl_wr) tot_mem[taddr] <= tnew_w;
    if (cmd.lvl_rd) trd_r <= tot_mem[taddr];
  end

  // Result.
  always_ff @(posedge clk) begin
    if (!rst_n) res_vld_r <= 1'b0;
    else res_vld_r <= cmd.emit || cmd.emit_fail;
    if (cmd.emit) begin
      res_r.ok          <= 1'b1;
      res_r.order_side  <= side_r;
      res_r.order_price <= lo_r + PW'(lvl_r);
      res_r.remaining   <= oldq_r;
      res_r.level_total <= tnew_w;
    end else if (cmd.emit_fail) begin
      res_r <= '0;
    end
  end

  assign res_vld = res_vld_r;
  assign res     = res_r;
endmodule

// File: hdl/plob_ctrl.sv
module plob_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  plob_pkg::plob_sts_t sts,
  output plob_pkg::plob_cmd_t cmd
);
  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CHK   = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_EVAL  = 4'd4;
  localparam logic [3:0] S_LRD   = 4'd5;
  localparam logic [3:0] S_LWR   = 4'd6;
  localparam logic [3:0] S_FAIL  = 4'd7;
  localparam logic [3:0] S_NEW   = 4'd8;

  logic [3:0] st_r, st_nxt;
  logic       ins_r, ins_nxt;  // probing to insert
  logic       rep2_r, rep2_nxt; // replace: old order removed, insert pending

  always_comb begin
    st_nxt   = st_r;
    ins_nxt  = ins_r;
    rep2_nxt = rep2_r;
    cmd      = '0;
    unique case (st_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          st_nxt   = S_CHK;
        end
      end
      S_CHK: begin
        ins_nxt  = sts.is_add;
        rep2_nxt = 1'b0;
        if ((sts.is_add || sts.is_repl) && !sts.price_ok) st_nxt = S_FAIL;
        else if (sts.is_add || sts.is_find || sts.is_repl) begin
          cmd.probe_rd = 1'b1;
          st_nxt = S_EVAL;
        end else st_nxt = S_FAIL;
      end
      S_RD: begin
        cmd.probe_rd = 1'b1;
        st_nxt = S_EVAL;
      end
      S_EVAL: begin
        priority if (ins_r ? sts.free : sts.hit) begin
          cmd.slot_wr = 1'b1;
          st_nxt = S_LRD;
        end else if ((!ins_r && sts.empty) || sts.probe_last) begin
          st_nxt = S_FAIL;
        end else begin
          cmd.probe_adv = 1'b1;
          st_nxt = S_RD;
        end
      end
      S_LRD: begin
        cmd.lvl_rd = 1'b1;
        st_nxt = S_LWR;
      end
      S_LWR: begin
        cmd.lvl_wr = 1'b1;
        if (sts.is_repl && !rep2_r) begin
          st_nxt = S_NEW;
        end else begin
          cmd.emit = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      S_NEW: begin
        cmd.find_new = 1'b1;
        ins_nxt  = 1'b1;
        rep2_nxt = 1'b1;
        st_nxt   = S_RD;
      end
      S_FAIL: begin
        cmd.emit_fail = 1'b1;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_CLR;
      ins_r  <= 1'b0;
      rep2_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      ins_r  <= ins_nxt;
      rep2_r <= rep2_nxt;
    end
  end

  assign busy = (st_r != S_IDLE);
endmodule

// File: hdl/price_level_order_book.sv
// Channel | Ports                                   | Handshake
// input   | start, busy, in_item                    | taken when start && !busy
// result  | out_valid, out_item                     | one cycle strobe, no stall
// config  | cfg_we, cfg_index, cfg_data             | written when cfg_we high
//
// An item holds busy through its probe steps, slot write and level update, and
// the next item is taken once busy falls; replace adds its insert probe and
// second level update, and a bad func or price fails without a probe. The
// single-port slot table read-modify-write sets the length of each item.
// After reset the slot flags and the level totals are swept in parallel;
// busy stays high until both sweeps end.
// The result strobe cannot be stalled; it follows the last level write.
module price_level_order_book #(
  parameter int unsigned TABLE_SLOTS  = plob_pkg::TableSlotsDef,
  parameter int unsigned PRICE_LEVELS = plob_pkg::PriceLevelsDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  plob_pkg::in_item_t           in_item,
  output logic                         out_valid,
  output plob_pkg::out_item_t          out_item,
  input  logic                         cfg_we,
  input  logic [plob_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [plob_pkg::PriceW-1:0]  cfg_data
);
  plob_pkg::plob_cmd_t cmd;
  plob_pkg::plob_sts_t sts;

  // Sequence each item: probe, update slot, update level, emit.
  plob_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
  );

  // Hold table, totals and configuration.
  plob_datapath #(.TABLE_SLOTS(TABLE_SLOTS), .PRICE_LEVELS(PRICE_LEVELS)) u_dp (
    .clk(clk), .rst_n(rst_n), .item(in_item), .cfg_we(cfg_we),
    .cfg_idx(cfg_index), .cfg_data(cfg_data), .cmd(cmd), .sts(sts),
    .res_vld(out_valid), .res(out_item)
  );
endmodule

// File: hdl/plob_checker.sv
`include "price_level_order_book_defines.svh"
module plob_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);
  `PLOB_ASSERT(a_busy_after_start, clk, rst_n, (start && !busy) |=> busy, "start not taken")
  `PLOB_ASSERT(a_out_while_busy, clk, rst_n, out_valid |-> !busy, "result while busy")
  `PLOB_ASSERT(a_out_one, clk, rst_n, out_valid |=> !out_valid, "result repeated")
  `PLOB_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid, "result after reset")
endmodule

bind price_level_order_book plob_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid)
);
